// ===== sv/bpa_pkg.sv =====
// ---------------------------------------------------------------------------
// bpa_pkg
// shared types and constants of the buddy page allocator
// ---------------------------------------------------------------------------
package bpa_pkg;

    localparam int MaxOrder  = 12;
    localparam int NPages    = 1 << MaxOrder;
    localparam int PageW     = MaxOrder;
    localparam int LinkW     = MaxOrder + 1;
    localparam int OrderW    = 4;
    localparam int BaseW     = 52;
    localparam int StepW     = MaxOrder + 1;

    typedef logic [PageW-1:0] t_page;
    typedef logic [LinkW-1:0] t_link;
    typedef logic [OrderW-1:0] t_order;

    localparam logic [BaseW-1:0] BaseReset = BaseW'(4096);

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_MEM  = 2'd1,
        ST_BAD_ORD = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_POP_RD,
        S_POP_WT,
        S_SPLIT,
        S_F_HEAD,
        S_F_POPRD,
        S_F_POPWT,
        S_WALK_RD,
        S_WALK_WT,
        S_UNL_RD,
        S_UNL_WT,
        S_APPEND,
        S_APP_TAIL,
        S_DONE
    } t_state;

endpackage

// ===== sv/buddy_page_allocator.sv =====
// ---------------------------------------------------------------------------
// buddy_page_allocator
// buddy allocator over 2^12 pages, one singly linked free list per order
// ---------------------------------------------------------------------------
// alloc scans up from the requested order, pops a head, splits down level by
//   level; free checks each list head, walks the links, merges with the buddy,
//   then links into an empty list or appends; a bad order goes straight to done
// one request at a time, result held in an output register until it is taken
// reset: synchronous active low; order 12 list holds page 0, others empty;
//   the link memory is not cleared, so a pop can read a link never written
module buddy_page_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [3:0]  i_block_order,
    input  logic [11:0] i_block_page,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [11:0] o_result_page,
    input  logic        i_cfg_we,
    input  logic [51:0] i_cfg_wdata,
    output logic [51:0] o_region_base_page
);

    bpa_pkg::t_state r_state, n_state;
    bpa_pkg::t_link  r_head [bpa_pkg::MaxOrder+1];
    bpa_pkg::t_link  r_mem  [bpa_pkg::NPages];
    bpa_pkg::t_link  r_rdata;

    bpa_pkg::t_order r_k, n_k, r_tk, n_tk;
    bpa_pkg::t_page  r_p, n_p, r_blk, n_blk, r_prev, n_prev;
    logic [bpa_pkg::StepW-1:0] r_steps, n_steps;
    logic [1:0]  r_status, n_status;
    bpa_pkg::t_page r_res, n_res;
    logic        r_out_valid, n_out_valid;
    logic [51:0] r_base;

    // memory and head write ports
    logic            mem_we;
    bpa_pkg::t_page  mem_wa, mem_ra;
    bpa_pkg::t_link  mem_wd;
    logic            head_we;
    bpa_pkg::t_order head_wa;
    bpa_pkg::t_link  head_wd;

    bpa_pkg::t_page  buddy;
    logic            has_buddy;
    bpa_pkg::t_link  hk;
    bpa_pkg::t_page  lowp;

    assign has_buddy = (r_k < bpa_pkg::t_order'(bpa_pkg::MaxOrder));
    assign buddy     = has_buddy ? (r_p ^ (bpa_pkg::t_page'(1) << r_k)) : '0;
    assign hk        = r_head[r_k];
    assign lowp      = (r_p < buddy) ? r_p : buddy;

    // sequencer
    always_comb begin
        n_state = r_state; n_k = r_k; n_tk = r_tk; n_p = r_p; n_blk = r_blk;
        n_prev = r_prev; n_steps = r_steps; n_status = r_status; n_res = r_res;
        n_out_valid = r_out_valid;
        mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_ra = r_prev;
        head_we = 1'b0; head_wa = r_k; head_wd = '0;
        o_in_ready = (r_state == bpa_pkg::S_IDLE) && !r_out_valid;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        unique case (r_state)
            bpa_pkg::S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_k = i_block_order; n_tk = i_block_order;
                    n_p = i_block_page; n_res = '0; n_status = bpa_pkg::ST_OK;
                    if (i_block_order > bpa_pkg::t_order'(bpa_pkg::MaxOrder)) begin
                        n_status = bpa_pkg::ST_BAD_ORD; n_state = bpa_pkg::S_DONE;
                    end else if (i_op == bpa_pkg::OP_ALLOC) begin
                        n_state = bpa_pkg::S_SCAN;
                    end else begin
                        n_state = bpa_pkg::S_F_HEAD;
                    end
                end
            end
            // find first non-empty order at or above the request
            bpa_pkg::S_SCAN: begin
                if (hk[bpa_pkg::PageW]) begin
                    n_blk = hk[bpa_pkg::PageW-1:0];
                    n_state = bpa_pkg::S_POP_RD;
                end else if (r_k == bpa_pkg::t_order'(bpa_pkg::MaxOrder)) begin
                    n_status = bpa_pkg::ST_NO_MEM; n_state = bpa_pkg::S_DONE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            bpa_pkg::S_POP_RD: begin
                mem_ra = r_blk; n_state = bpa_pkg::S_POP_WT;
            end
            bpa_pkg::S_POP_WT: begin
                head_we = 1'b1;
                head_wd = r_rdata[bpa_pkg::PageW] ? r_rdata : '0;
                n_state = bpa_pkg::S_SPLIT;
            end
            // one split level per cycle
            bpa_pkg::S_SPLIT: begin
                if (r_k == r_tk) begin
                    n_res = r_blk; n_state = bpa_pkg::S_DONE;
                end else begin
                    head_we = 1'b1; head_wa = r_k - 1'b1;
                    head_wd = {1'b1, r_blk};
                    mem_we = 1'b1; mem_wa = r_blk; mem_wd = '0;
                    n_blk = r_blk + (bpa_pkg::t_page'(1) << (r_k - 1'b1));
                    n_k = r_k - 1'b1;
                end
            end
            // free: inspect head of list k
            bpa_pkg::S_F_HEAD: begin
                n_steps = '0;
                if (!hk[bpa_pkg::PageW]) begin
                    head_we = 1'b1; head_wd = {1'b1, r_p};
                    mem_we = 1'b1; mem_wa = r_p; mem_wd = '0;
                    n_state = bpa_pkg::S_DONE;
                end else if (has_buddy && hk[bpa_pkg::PageW-1:0] == buddy) begin
                    n_state = bpa_pkg::S_F_POPRD;
                end else begin
                    n_prev = hk[bpa_pkg::PageW-1:0];
                    n_state = bpa_pkg::S_WALK_RD;
                end
            end
            bpa_pkg::S_F_POPRD: begin
                mem_ra = buddy; n_state = bpa_pkg::S_F_POPWT;
            end
            bpa_pkg::S_F_POPWT: begin
                head_we = 1'b1;
                head_wd = r_rdata[bpa_pkg::PageW] ? r_rdata : '0;
                n_p = lowp; n_k = r_k + 1'b1; n_state = bpa_pkg::S_F_HEAD;
            end
            bpa_pkg::S_WALK_RD: begin
                mem_ra = r_prev; n_state = bpa_pkg::S_WALK_WT;
            end
            bpa_pkg::S_WALK_WT: begin
                if (!r_rdata[bpa_pkg::PageW]) begin
                    n_state = bpa_pkg::S_APPEND;
                end else if (has_buddy && r_rdata[bpa_pkg::PageW-1:0] == buddy) begin
                    n_state = bpa_pkg::S_UNL_RD;
                end else if (r_steps == bpa_pkg::StepW'(bpa_pkg::NPages - 1)) begin
                    n_state = bpa_pkg::S_DONE;
                end else begin
                    n_prev = r_rdata[bpa_pkg::PageW-1:0];
                    n_steps = r_steps + 1'b1;
                    n_state = bpa_pkg::S_WALK_RD;
                end
            end
            bpa_pkg::S_UNL_RD: begin
                mem_ra = buddy; n_state = bpa_pkg::S_UNL_WT;
            end
            bpa_pkg::S_UNL_WT: begin
                mem_we = 1'b1; mem_wa = r_prev; mem_wd = r_rdata;
                n_p = lowp; n_k = r_k + 1'b1; n_state = bpa_pkg::S_F_HEAD;
            end
            // link the block after the tail
            bpa_pkg::S_APPEND: begin
                mem_we = 1'b1; mem_wa = r_prev; mem_wd = {1'b1, r_p};
                n_steps = '0;
                n_state = bpa_pkg::S_APP_TAIL;
            end
            // terminate the list at the new tail, last so it wins on a self link
            bpa_pkg::S_APP_TAIL: begin
                mem_we = 1'b1; mem_wa = r_p; mem_wd = '0;
                n_state = bpa_pkg::S_DONE;
            end
            bpa_pkg::S_DONE: begin
                n_out_valid = 1'b1;
                n_state = bpa_pkg::S_IDLE;
            end
            default: n_state = bpa_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_base <= bpa_pkg::BaseReset;
            for (int i = 0; i <= bpa_pkg::MaxOrder; i++) begin
                r_head[i] <= (i == bpa_pkg::MaxOrder) ? {1'b1, bpa_pkg::t_page'(0)} : '0;
            end
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) r_base <= i_cfg_wdata;
            if (head_we) r_head[head_wa] <= head_wd;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_k <= n_k; r_tk <= n_tk; r_p <= n_p; r_blk <= n_blk;
        r_prev <= n_prev; r_steps <= n_steps; r_status <= n_status; r_res <= n_res;
    end

    // link memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[mem_ra];
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_result_page      = r_res;
    assign o_region_base_page = r_base;

endmodule

// ===== tb/buddy_page_allocator_tb.sv =====
// ---------------------------------------------------------------------------
// buddy_page_allocator_tb
// self-checking bench: alloc/free traffic through the valid/ready ports,
// a free-list predictor for the expected status and page, random idling
// ---------------------------------------------------------------------------
module buddy_page_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int Phases    = 4;
    localparam int PhaseLen  = 400;
    localparam int QuietTail = 150;
    localparam int SettleCyc = 8;
    localparam int DogLimit  = 200000;
    localparam int MaxShown  = 10;

    typedef enum logic [1:0] {
        K_REQ,
        K_CFG,
        K_HOLD
    } t_kind;

    typedef struct packed {
        t_kind                              kind;
        bpa_pkg::t_op                       op;
        bpa_pkg::t_order                    order;
        bpa_pkg::t_page                     page;
        logic [bpa_pkg::BaseW-1:0]          base;
    } t_pending;

    typedef struct packed {
        bpa_pkg::t_status status;
        bpa_pkg::t_page   page;
    } t_outcome;

    typedef struct packed {
        bpa_pkg::t_page  page;
        bpa_pkg::t_order order;
    } t_block;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic             i_op;
    logic [3:0]       i_block_order;
    logic [11:0]      i_block_page;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [1:0]       o_status;
    logic [11:0]      o_result_page;
    logic             i_cfg_we;
    logic [51:0]      i_cfg_wdata;
    logic [51:0]      o_region_base_page;

    // predictor state: list heads per order and next links per page
    bpa_pkg::t_link list_head [bpa_pkg::MaxOrder+1];
    bpa_pkg::t_link next_page [bpa_pkg::NPages];

    t_pending    pending_q [$];
    t_outcome    outcome_q [$];
    t_block      owned_q   [$];

    int          n_sent;
    int          n_got;
    int          n_bad;
    int          total_reqs;
    int          dog;
    logic        stim_done;

    buddy_page_allocator dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_op               (i_op),
        .i_block_order      (i_block_order),
        .i_block_page       (i_block_page),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_result_page      (o_result_page),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_region_base_page (o_region_base_page)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // pop the head of one free list
    function automatic bpa_pkg::t_page take_head(int k);
        bpa_pkg::t_page pg;
        bpa_pkg::t_link nx;
        pg = list_head[k][bpa_pkg::PageW-1:0];
        nx = next_page[pg];
        list_head[k] = nx[bpa_pkg::MaxOrder] ? nx : '0;
        return pg;
    endfunction

    // free with buddy merge cascade
    function automatic void give_back(bpa_pkg::t_page pg, int k);
        bpa_pkg::t_page buddy;
        bpa_pkg::t_page prev;
        bpa_pkg::t_page nxp;
        bpa_pkg::t_link nx;
        int    steps;
        bit    found;
        bit    has_buddy;
        bit    done;
        done = 0;
        while (!done) begin
            has_buddy = (k < bpa_pkg::MaxOrder);
            buddy = has_buddy ? (pg ^ bpa_pkg::t_page'(1 << k)) : '0;
            found = 0;
            steps = 0;
            if (!list_head[k][bpa_pkg::MaxOrder]) begin
                list_head[k] = {1'b1, pg};
                next_page[pg] = '0;
                done = 1;
            end else if (has_buddy && list_head[k][bpa_pkg::PageW-1:0] == buddy) begin
                void'(take_head(k));
                pg = (pg < buddy) ? pg : buddy;
                k++;
            end else begin
                prev = list_head[k][bpa_pkg::PageW-1:0];
                while (steps < bpa_pkg::NPages) begin
                    nx = next_page[prev];
                    if (!nx[bpa_pkg::MaxOrder]) break;
                    nxp = nx[bpa_pkg::PageW-1:0];
                    if (has_buddy && nxp == buddy) begin
                        next_page[prev] = next_page[nxp];
                        found = 1;
                        break;
                    end
                    prev = nxp;
                    steps++;
                end
                if (found) begin
                    pg = (pg < buddy) ? pg : buddy;
                    k++;
                end else begin
                    // runaway walk leaves the lists as they are
                    if (steps < bpa_pkg::NPages) begin
                        next_page[prev] = {1'b1, pg};
                        next_page[pg] = '0;
                    end
                    done = 1;
                end
            end
        end
    endfunction

    // expected outcome of one request, updating the predicted lists
    function automatic t_outcome run_request(bpa_pkg::t_op op, bpa_pkg::t_order ord,
                                             bpa_pkg::t_page pg);
        t_outcome       res;
        int             idx;
        bpa_pkg::t_page blk;
        res = '{status: bpa_pkg::ST_OK, page: '0};
        if (ord > bpa_pkg::MaxOrder) begin
            res.status = bpa_pkg::ST_BAD_ORD;
        end else if (op == bpa_pkg::OP_ALLOC) begin
            idx = ord;
            while (idx <= bpa_pkg::MaxOrder && !list_head[idx][bpa_pkg::MaxOrder]) idx++;
            if (idx > bpa_pkg::MaxOrder) begin
                res.status = bpa_pkg::ST_NO_MEM;
            end else begin
                blk = take_head(idx);
                while (idx > ord) begin
                    idx--;
                    list_head[idx] = {1'b1, blk};
                    next_page[blk] = '0;
                    blk = blk + bpa_pkg::t_page'(1 << idx);
                end
                res.page = blk;
            end
        end else begin
            give_back(pg, ord);
        end
        return res;
    endfunction

    task automatic add_req(bpa_pkg::t_op op, bpa_pkg::t_order ord, bpa_pkg::t_page pg);
        t_outcome res;
        res = run_request(op, ord, pg);
        outcome_q.push_back(res);
        pending_q.push_back('{kind: K_REQ, op: op, order: ord, page: pg, base: '0});
        if (op == bpa_pkg::OP_ALLOC && res.status == bpa_pkg::ST_OK)
            owned_q.push_back('{page: res.page, order: ord});
    endtask

    task automatic add_marker(t_kind kind, logic [bpa_pkg::BaseW-1:0] base);
        pending_q.push_back('{kind: kind, op: bpa_pkg::OP_ALLOC, order: '0, page: '0,
                              base: base});
    endtask

    // one random request: mostly well-formed alloc/free, some noise
    task automatic add_random();
        int              pick;
        int              sel;
        bpa_pkg::t_order ord;
        t_block          blk;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            add_req(bpa_pkg::t_op'($urandom_range(0, 1)),
                    bpa_pkg::t_order'($urandom_range(0, 15)),
                    bpa_pkg::t_page'($urandom_range(0, bpa_pkg::NPages - 1)));
        end else if (pick < 50 && owned_q.size() > 0) begin
            sel = $urandom_range(0, owned_q.size() - 1);
            blk = owned_q[sel];
            owned_q.delete(sel);
            add_req(bpa_pkg::OP_FREE, blk.order, blk.page);
        end else begin
            if ($urandom_range(0, 9) == 0)
                ord = bpa_pkg::t_order'($urandom_range(0, 15));
            else
                ord = bpa_pkg::t_order'($urandom_range(0, 4));
            add_req(bpa_pkg::OP_ALLOC, ord,
                    bpa_pkg::t_page'($urandom_range(0, bpa_pkg::NPages - 1)));
        end
    endtask

    // stimulus and end of run
    initial begin
        logic [bpa_pkg::BaseW-1:0] bases [Phases];
        bpa_pkg::t_page            got [5];
        bpa_pkg::t_order           ords [5];
        for (int k = 0; k <= bpa_pkg::MaxOrder; k++) list_head[k] = '0;
        for (int p = 0; p < bpa_pkg::NPages; p++) next_page[p] = '0;
        list_head[bpa_pkg::MaxOrder] = {1'b1, bpa_pkg::t_page'(0)};
        bases[0] = '0;
        bases[1] = '1;
        bases[2] = bpa_pkg::BaseW'({$urandom, $urandom});
        bases[3] = bpa_pkg::BaseReset;
        ords = '{0, 1, 2, 5, 11};

        i_rst_n = 1'b0;
        stim_done = 1'b0;
        total_reqs = 0;

        // the link of page 0 gets written before the first pop reads it
        add_req(bpa_pkg::OP_FREE, 0, 0);
        add_req(bpa_pkg::OP_ALLOC, 0, 0);
        // order out of range
        add_req(bpa_pkg::OP_ALLOC, 13, 0);
        add_req(bpa_pkg::OP_ALLOC, 15, 12'hfff);
        add_req(bpa_pkg::OP_FREE, 15, 12'hfff);
        // whole region, then nothing free
        add_req(bpa_pkg::OP_ALLOC, bpa_pkg::MaxOrder, 0);
        add_req(bpa_pkg::OP_ALLOC, 0, 0);
        // top order has no buddy
        add_req(bpa_pkg::OP_FREE, bpa_pkg::MaxOrder, 0);
        for (int i = 0; i < 5; i++) begin
            add_req(bpa_pkg::OP_ALLOC, ords[i], 0);
            got[i] = outcome_q[outcome_q.size() - 1].page;
        end
        void'(owned_q.pop_back());
        for (int i = 0; i < 4; i++) void'(owned_q.pop_back());
        // merge cascade back up to one block
        for (int i = 4; i >= 0; i--) add_req(bpa_pkg::OP_FREE, ords[i], got[i]);
        add_marker(K_HOLD, '0);
        // unchecked frees: unaligned and double
        add_req(bpa_pkg::OP_FREE, 2, 12'hfff);
        add_req(bpa_pkg::OP_FREE, 0, 12'h555);
        add_req(bpa_pkg::OP_FREE, 0, 12'h555);
        add_req(bpa_pkg::OP_ALLOC, 0, 0);

        for (int ph = 0; ph < Phases; ph++) begin
            add_marker(K_CFG, bases[ph]);
            for (int i = 0; i < PhaseLen; i++) add_random();
            add_marker(K_HOLD, '0);
        end
        total_reqs = outcome_q.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        stim_done = 1'b1;
        wait (pending_q.size() == 0 && outcome_q.size() == 0);
        repeat (SettleCyc * 4) @(posedge i_clk);
        if (n_bad == 0 && n_got == n_sent)
            $display("PASS buddy_page_allocator");
        else
            $display("FAIL buddy_page_allocator");
        $finish;
    end

    // driver: requests, register writes and pauses from the pending queue
    always @(posedge i_clk) begin
        t_pending nxt;
        int       sent;
        int       gap;
        int       settle;
        bit       idle;
        bit       cfg_we;
        if (!i_rst_n) begin
            i_in_valid    <= 1'b0;
            i_op          <= 1'b0;
            i_block_order <= '0;
            i_block_page  <= '0;
            i_cfg_we      <= 1'b0;
            i_cfg_wdata   <= '0;
            n_sent        <= 0;
            gap = 0;
            settle = SettleCyc;
        end else if (!(i_in_valid && !o_in_ready)) begin
            sent = n_sent;
            cfg_we = 1'b0;
            if (i_in_valid) begin
                sent++;
                void'(pending_q.pop_front());
            end
            n_sent <= sent;
            idle = (sent == n_got) && !o_out_valid;
            settle = idle ? ((settle > 0) ? settle - 1 : 0) : SettleCyc;
            if (gap > 0) begin
                gap--;
                i_in_valid <= 1'b0;
            end else if (pending_q.size() > 0 && stim_done) begin
                nxt = pending_q[0];
                if (nxt.kind == K_REQ) begin
                    i_in_valid    <= 1'b1;
                    i_op          <= nxt.op;
                    i_block_order <= nxt.order;
                    i_block_page  <= nxt.page;
                    if (sent < total_reqs - QuietTail && $urandom_range(0, 7) == 0)
                        gap = $urandom_range(1, 4);
                end else begin
                    i_in_valid <= 1'b0;
                    if (idle && settle == 0) begin
                        if (nxt.kind == K_CFG) begin
                            cfg_we = 1'b1;
                            i_cfg_wdata <= nxt.base;
                        end
                        void'(pending_q.pop_front());
                    end
                end
            end else begin
                i_in_valid <= 1'b0;
            end
            i_cfg_we <= cfg_we;
        end
    end

    // monitor: result transfers against the expected outcomes
    always @(posedge i_clk) begin
        t_outcome want;
        int       stall;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            n_got       <= 0;
            n_bad       <= 0;
            stall = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_got <= n_got + 1;
                if (outcome_q.size() == 0) begin
                    if (n_bad < MaxShown)
                        $display("unexpected result: status %0d page %0d",
                                 o_status, o_result_page);
                    n_bad <= n_bad + 1;
                end else begin
                    want = outcome_q.pop_front();
                    if (o_status !== want.status || o_result_page !== want.page) begin
                        if (n_bad < MaxShown)
                            $display("result %0d: expected status %0d page %0d, got %0d %0d",
                                     n_got, want.status, want.page,
                                     o_status, o_result_page);
                        n_bad <= n_bad + 1;
                    end
                end
            end
            // receiver stall bursts, none near the end
            if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else if (n_sent < total_reqs - QuietTail && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(0, 3);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || i_cfg_we) begin
            dog <= 0;
        end else if (dog >= DogLimit) begin
            $display("FAIL buddy_page_allocator");
            $finish;
        end else begin
            dog <= dog + 1;
        end
    end

endmodule

// ===== sim.f =====
sv/bpa_pkg.sv
sv/buddy_page_allocator.sv
tb/buddy_page_allocator_tb.sv
